// ===== design/mbsn_pkg.sv =====
// ----------------------------------------------------------------------------
// mbsn_pkg
// Shared constants, configuration codes and types of the Modbus register-read
// sniffer.
// ----------------------------------------------------------------------------
package mbsn_pkg;

    localparam int FRAME_BUFFER_LEN = 20;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  RST_SLAVE_ADDRESS    = 8'h01;
    localparam logic [7:0]  RST_FUNCTION_CODE    = 8'h03;
    localparam logic [15:0] RST_WATCHED_REGISTER = 16'h5000;
    localparam logic [15:0] RST_JUMP_LIMIT       = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE_ADDRESS    = 4'd0,
        CFG_FUNCTION_CODE    = 4'd1,
        CFG_WATCHED_REGISTER = 4'd2,
        CFG_JUMP_LIMIT       = 4'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [15:0] watched_register;
        logic [15:0] jump_limit;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic [63:0] count;
    } t_event;

endpackage

// ===== design/mbsn_if.sv =====
// ----------------------------------------------------------------------------
// mbsn channel interfaces
// Valid/ready channels for received bytes, readings and register writes.
// ----------------------------------------------------------------------------
interface mbsn_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbsn_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] reading;
    logic        held_back;

    modport source (output valid, output reading, output held_back, input ready);
    modport sink   (input valid, input reading, input held_back, output ready);
endinterface

interface mbsn_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mbsn_pkg::CFG_IDX_W-1:0]  index;
    logic [mbsn_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/mbsn_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mbsn_cfg_regs
// Configuration register file; one write per transaction, always ready.
// ----------------------------------------------------------------------------
module mbsn_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [mbsn_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [mbsn_pkg::CFG_DATA_W-1:0] i_data,
    output logic                            o_ready,
    output mbsn_pkg::t_cfg                  o_cfg
);

    mbsn_pkg::t_cfg r_cfg;
    mbsn_pkg::t_cfg n_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_valid) begin
            case (mbsn_pkg::t_cfg_idx'(i_index))
                mbsn_pkg::CFG_SLAVE_ADDRESS:    n_cfg.slave_address    = i_data[7:0];
                mbsn_pkg::CFG_FUNCTION_CODE:    n_cfg.function_code    = i_data[7:0];
                mbsn_pkg::CFG_WATCHED_REGISTER: n_cfg.watched_register = i_data[15:0];
                mbsn_pkg::CFG_JUMP_LIMIT:       n_cfg.jump_limit       = i_data[15:0];
                default:                        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address    <= mbsn_pkg::RST_SLAVE_ADDRESS;
            r_cfg.function_code    <= mbsn_pkg::RST_FUNCTION_CODE;
            r_cfg.watched_register <= mbsn_pkg::RST_WATCHED_REGISTER;
            r_cfg.jump_limit       <= mbsn_pkg::RST_JUMP_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== design/mbsn_frame.sv =====
// ----------------------------------------------------------------------------
// mbsn_frame
// Frame capture: header check, byte store, close detection and request
// tracking. Emits the big-endian count of a response frame as an event.
// ----------------------------------------------------------------------------
module mbsn_frame #(
    parameter int FRAME_LEN = mbsn_pkg::FRAME_BUFFER_LEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbsn_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    input  logic [7:0]         i_rx_byte,
    output logic               o_ready,
    output mbsn_pkg::t_event   o_event,
    input  logic               i_event_ready
);

    localparam int              FP_W    = $clog2(FRAME_LEN);
    localparam logic [FP_W-1:0] FP_LAST = FP_W'(FRAME_LEN - 1);
    localparam logic [FP_W-1:0] FP_HDR  = FP_W'(2);
    localparam logic [FP_W-1:0] FP_MIN  = FP_W'(3);

    logic             r_rec;
    logic [FP_W-1:0]  r_fp;
    logic [7:0]       r_buf [FRAME_LEN];
    logic             r_pend;
    mbsn_pkg::t_event r_event;

    logic             n_rec;
    logic [FP_W-1:0]  n_fp;
    logic             n_pend;
    mbsn_pkg::t_event n_event;

    logic             accept;
    logic             start;
    logic             active;
    logic [FP_W-1:0]  fp_base;
    logic             s_rec;
    logic [FP_W-1:0]  s_fp;
    logic [7:0]       s_buf [FRAME_LEN];
    logic [FRAME_LEN-1:0] pair;
    logic             close;
    logic [63:0]      count;
    logic [15:0]      reg_field;

    assign o_ready = !r_event.valid || i_event_ready;
    assign o_event = r_event;
    assign accept  = i_valid && o_ready;
    assign start   = !r_rec && (i_rx_byte == i_cfg.slave_address);
    assign active  = accept && (r_rec || start);
    assign fp_base = start ? '0 : r_fp;

    // store step
    always_comb begin
        s_buf = r_buf;
        s_fp  = fp_base;
        s_rec = 1'b1;
        if (fp_base < FP_LAST) begin
            s_buf[fp_base]      = i_rx_byte;
            s_buf[fp_base + 1'b1] = 8'h00;
            s_fp                = fp_base + 1'b1;
        end else begin
            s_rec = 1'b0;
        end
    end

    // address/function pairs at byte 2 and later
    always_comb begin
        pair = '0;
        for (int j = 2; j < FRAME_LEN - 1; j++) begin
            pair[j] = (s_buf[j] == i_cfg.slave_address) &&
                      (s_buf[j+1] == i_cfg.function_code) &&
                      (FP_W'(j + 1) < s_fp);
        end
    end

    assign close = (s_fp > FP_MIN) && !pair[2] && (|pair);

    always_comb begin
        count = '0;
        for (int k = 3; k <= 10; k++) begin
            count = {count[55:0], s_buf[k]};
        end
    end

    assign reg_field = {s_buf[2], s_buf[3]};

    always_comb begin
        n_rec   = r_rec;
        n_fp    = r_fp;
        n_pend  = r_pend;
        n_event = r_event;
        if (i_event_ready) begin
            n_event.valid = 1'b0;
        end
        if (active) begin
            n_rec = s_rec;
            n_fp  = s_fp;
            if (s_fp == FP_HDR) begin
                if (!(s_buf[0] == i_cfg.slave_address && s_buf[1] == i_cfg.function_code)) begin
                    n_rec = 1'b0;
                end
            end else if (close) begin
                n_fp   = FP_HDR;
                n_pend = (reg_field == i_cfg.watched_register);
                if (r_pend) begin
                    n_event.valid = 1'b1;
                    n_event.count = count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec         <= 1'b0;
            r_fp          <= '0;
            r_pend        <= 1'b0;
            r_event.valid <= 1'b0;
            r_event.count <= '0;
            for (int i = 0; i < FRAME_LEN; i++) begin
                r_buf[i] <= 8'h00;
            end
        end else begin
            r_rec   <= n_rec;
            r_fp    <= n_fp;
            r_pend  <= n_pend;
            r_event <= n_event;
            if (active) begin
                r_buf <= s_buf;
            end
        end
    end

endmodule

// ===== design/mbsn_hold.sv =====
// ----------------------------------------------------------------------------
// mbsn_hold
// Plausibility hold on the meter count and the result register.
// ----------------------------------------------------------------------------
module mbsn_hold (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [15:0]      i_jump_limit,
    input  mbsn_pkg::t_event i_event,
    output logic             o_event_ready,
    output logic             o_valid,
    output logic [63:0]      o_reading,
    output logic             o_held_back,
    input  logic             i_ready
);

    logic [63:0] r_last;
    logic        r_valid;
    logic [63:0] r_reading;
    logic        r_held;

    logic [63:0] limit;
    logic [63:0] diff;
    logic        held;
    logic        take;

    assign o_event_ready = !r_valid || i_ready;
    assign take          = i_event.valid && o_event_ready;
    assign limit         = {48'd0, i_jump_limit};
    assign diff          = i_event.count - r_last;
    assign held          = (r_last >= limit) && (i_event.count > r_last) && (diff > limit);

    assign o_valid     = r_valid;
    assign o_reading   = r_reading;
    assign o_held_back = r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_last  <= held ? r_last : i_event.count;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_reading <= held ? r_last : i_event.count;
            r_held    <= held;
        end
    end

endmodule

// ===== design/modbus_register_read_sniffer.sv =====
// ----------------------------------------------------------------------------
// modbus_register_read_sniffer
// Watches sniffed Modbus bytes and reports the meter count carried by the
// response to a watched register request.
//
//   channel   dir  payload                       role
//   i_byte    in   rx_byte[7:0]                  sniffed line bytes
//   o_result  out  reading[63:0], held_back      meter readings
//   i_cfg     in   index[3:0], data[15:0]        register writes
//
// One byte per cycle while i_byte.ready is high. A reading is registered
// from the byte that closes the response frame into the frame register and
// then the result register. Synchronous reset restores register defaults and
// clears the frame buffer. A stalled result keeps bytes flowing until one
// more reading waits behind it; then i_byte.ready drops until o_result is taken.
// ----------------------------------------------------------------------------
module modbus_register_read_sniffer #(
    parameter int FRAME_LEN = mbsn_pkg::FRAME_BUFFER_LEN
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mbsn_byte_if.sink            i_byte,
    mbsn_result_if.source        o_result,
    mbsn_cfg_if.sink             i_cfg
);

    mbsn_pkg::t_cfg   cfg;
    mbsn_pkg::t_event evt;
    logic             evt_ready;

    mbsn_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_ready (i_cfg.ready),
        .o_cfg   (cfg)
    );

    mbsn_frame #(
        .FRAME_LEN (FRAME_LEN)
    ) u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_byte.valid),
        .i_rx_byte     (i_byte.rx_byte),
        .o_ready       (i_byte.ready),
        .o_event       (evt),
        .i_event_ready (evt_ready)
    );

    mbsn_hold u_hold (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_jump_limit  (cfg.jump_limit),
        .i_event       (evt),
        .o_event_ready (evt_ready),
        .o_valid       (o_result.valid),
        .o_reading     (o_result.reading),
        .o_held_back   (o_result.held_back),
        .i_ready       (o_result.ready)
    );

endmodule

// ===== design/mbsn_checker.sv =====
// ----------------------------------------------------------------------------
// mbsn_checker
// Port-level checks on the sniffer, bound to the top level.
// ----------------------------------------------------------------------------
module mbsn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_reading,
    input logic        i_held_back
);

    logic [63:0] r_prev_reading;
    logic        in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_reading <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_prev_reading <= i_reading;
        end
    end

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped before transaction");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_reading) && $stable(i_held_back))
        else $error("stalled result changed");

    a_held_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_held_back |-> i_reading == r_prev_reading)
        else $error("held reading differs from previous reading");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_acc, 2))
        else $error("result without closing byte two cycles earlier");

endmodule

bind modbus_register_read_sniffer mbsn_checker u_mbsn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_reading   (o_result.reading),
    .i_held_back (o_result.held_back)
);

// ===== tb/sv/modbus_register_read_sniffer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_register_read_sniffer_checker
// Watches the byte, result and register-write channels of the sniffer. Every
// byte transaction runs through a frame tracker of its own that rebuilds the
// recording, the frame buffer, the pending request and the last reading. Each
// meter reading it derives is queued and compared against the next result
// transaction. Mismatches, unexpected results and the open count go to the top.
// ----------------------------------------------------------------------------
module modbus_register_read_sniffer_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_byte_valid,
    input  logic                            i_byte_ready,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic [63:0]                     i_reading,
    input  logic                            i_held_back,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [mbsn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbsn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_outstanding,
    output int                              o_checked,
    output int                              o_held_seen
);
    import mbsn_pkg::*;

    typedef struct packed {
        logic [63:0] reading;
        logic        held_back;
    } t_reading;

    t_cfg        cfg_now;
    logic        recording;
    logic [4:0]  fill_pos;
    logic [7:0]  frame_mem [FRAME_BUFFER_LEN];
    logic        req_pending;
    logic [63:0] last_reading;
    t_reading    expected_readings [$];
    int          mismatches;
    int          checked;
    int          held_seen;

    task automatic reset_tracker();
        cfg_now.slave_address    = RST_SLAVE_ADDRESS;
        cfg_now.function_code    = RST_FUNCTION_CODE;
        cfg_now.watched_register = RST_WATCHED_REGISTER;
        cfg_now.jump_limit       = RST_JUMP_LIMIT;
        recording    = 1'b0;
        fill_pos     = '0;
        req_pending  = 1'b0;
        last_reading = '0;
        for (int i = 0; i < FRAME_BUFFER_LEN; i++) begin
            frame_mem[i] = '0;
        end
        expected_readings.delete();
    endtask

    task automatic close_frame();
        logic [15:0] reg_word;
        logic [63:0] count;
        logic [63:0] limit;
        logic        held;
        t_reading    entry;
        reg_word = {frame_mem[2], frame_mem[3]};
        limit    = {48'd0, cfg_now.jump_limit};
        if (req_pending) begin
            req_pending = 1'b0;
            count = {frame_mem[3], frame_mem[4], frame_mem[5], frame_mem[6],
                     frame_mem[7], frame_mem[8], frame_mem[9], frame_mem[10]};
            held = (last_reading >= limit) && (count > last_reading) &&
                   (count - last_reading > limit);
            if (held) begin
                count = last_reading;
            end
            last_reading    = count;
            entry.reading   = count;
            entry.held_back = held;
            expected_readings.push_back(entry);
        end
        if (reg_word == cfg_now.watched_register) begin
            req_pending = 1'b1;
        end
    endtask

    task automatic track_byte(input logic [7:0] b);
        logic found;
        found = 1'b0;
        if (!recording && b == cfg_now.slave_address) begin
            recording = 1'b1;
            fill_pos  = '0;
        end
        if (!recording) begin
            return;
        end
        if (fill_pos < FRAME_BUFFER_LEN - 1) begin
            frame_mem[fill_pos] = b;
            fill_pos = fill_pos + 1'b1;
            frame_mem[fill_pos] = '0;
        end else begin
            recording = 1'b0;
        end
        if (fill_pos == 2) begin
            if (!(frame_mem[0] == cfg_now.slave_address &&
                  frame_mem[1] == cfg_now.function_code)) begin
                recording = 1'b0;
            end
            return;
        end
        if (fill_pos > 3) begin
            for (int j = 2; j + 1 < fill_pos && !found; j++) begin
                if (frame_mem[j] == cfg_now.slave_address &&
                    frame_mem[j+1] == cfg_now.function_code) begin
                    found = 1'b1;
                    if (j > 2) begin
                        fill_pos = 5'd2;
                        close_frame();
                    end
                end
            end
        end
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (t_cfg_idx'(idx))
            CFG_SLAVE_ADDRESS:    cfg_now.slave_address    = data[7:0];
            CFG_FUNCTION_CODE:    cfg_now.function_code    = data[7:0];
            CFG_WATCHED_REGISTER: cfg_now.watched_register = data;
            CFG_JUMP_LIMIT:       cfg_now.jump_limit       = data;
            default: ;
        endcase
    endtask

    initial begin
        mismatches = 0;
        checked    = 0;
        held_seen  = 0;
        reset_tracker();
        o_mismatches  = 0;
        o_outstanding = 0;
        o_checked     = 0;
        o_held_seen   = 0;
    end

    always @(posedge i_clk) begin
        t_reading entry;
        if (!i_rst_n) begin
            reset_tracker();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_readings.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected reading, expected none, actual %h held %b",
                             $time, i_reading, i_held_back);
                end else begin
                    entry = expected_readings.pop_front();
                    checked++;
                    if (i_held_back) begin
                        held_seen++;
                    end
                    if (i_reading !== entry.reading) begin
                        mismatches++;
                        $display("%0t: reading mismatch, expected %h actual %h",
                                 $time, entry.reading, i_reading);
                    end
                    if (i_held_back !== entry.held_back) begin
                        mismatches++;
                        $display("%0t: held_back mismatch, expected %b actual %b",
                                 $time, entry.held_back, i_held_back);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                write_setting(i_cfg_index, i_cfg_data);
            end
            if (i_byte_valid && i_byte_ready) begin
                track_byte(i_rx_byte);
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_readings.size();
        o_checked     <= checked;
        o_held_seen   <= held_seen;
    end

endmodule

// ===== tb/sv/modbus_register_read_sniffer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_register_read_sniffer_tb
// Drives sniffed bytes into the sniffer: a short hand-made request/response
// exchange at reset settings, then phases of random traffic under changing
// register settings. Traffic is mostly well-formed request/response pairs
// with meter counts near the previous one, mixed with short, overlong and
// broken frames and line noise. Both sides idle at random. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module modbus_register_read_sniffer_tb;
    import mbsn_pkg::*;

    localparam int                 NUM_PHASES     = 12;
    localparam int                 PHASE_BYTES    = 150;
    localparam int                 DRAIN_CYCLES   = 4;
    localparam int                 TAIL_CYCLES    = 10;
    localparam int                 WATCHDOG_LIMIT = 3000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'hF;

    logic i_clk;
    logic i_rst_n;

    mbsn_byte_if   byte_ch ();
    mbsn_result_if result_ch ();
    mbsn_cfg_if    cfg_ch ();

    int mismatches;
    int outstanding;
    int checked;
    int held_seen;

    logic [7:0]  cur_addr;
    logic [7:0]  cur_fc;
    logic [15:0] cur_watch;
    logic [15:0] cur_limit;
    logic [63:0] meter;
    logic        no_gap;
    int          bytes_sent;
    int          settings_count;

    logic [7:0] directed_bytes [21] = '{
        8'h00, 8'hFF,
        8'h01, 8'h55,
        8'h01, 8'h03, 8'h50, 8'h00,
        8'h01, 8'h03, 8'h08,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h01, 8'h03
    };

    modbus_register_read_sniffer i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    modbus_register_read_sniffer_checker u_reading_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (byte_ch.valid),
        .i_byte_ready  (byte_ch.ready),
        .i_rx_byte     (byte_ch.rx_byte),
        .i_res_valid   (result_ch.valid),
        .i_res_ready   (result_ch.ready),
        .i_reading     (result_ch.reading),
        .i_held_back   (result_ch.held_back),
        .i_cfg_valid   (cfg_ch.valid),
        .i_cfg_ready   (cfg_ch.ready),
        .i_cfg_index   (cfg_ch.index),
        .i_cfg_data    (cfg_ch.data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_held_seen   (held_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gap || r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] next_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            meter = meter + 64'($urandom_range(0, cur_limit));
        end else if (r < 70) begin
            meter = meter + 64'(cur_limit) + 64'($urandom_range(1, 5000));
        end else if (r < 82) begin
            meter = meter - (meter >> $urandom_range(1, 8)) - 64'($urandom_range(0, 3));
        end else if (r < 92) begin
            meter = {$urandom, $urandom};
        end else if (r < 96) begin
            meter = '0;
        end else begin
            meter = '1;
        end
        return meter;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_random_bytes(input int n);
        for (int i = 0; i < n; i++) begin
            send_byte(rand_byte());
        end
    endtask

    task automatic send_request(input logic [15:0] reg_word);
        send_byte(cur_addr);
        send_byte(cur_fc);
        send_byte(reg_word[15:8]);
        send_byte(reg_word[7:0]);
        send_byte(8'h00);
        send_byte(8'h04);
        send_random_bytes(2);
    endtask

    task automatic send_response(input logic [63:0] count, input int data_len);
        send_byte(cur_addr);
        send_byte(cur_fc);
        send_byte(8'(data_len));
        for (int i = 0; i < data_len; i++) begin
            send_byte(count[63-8*i -: 8]);
        end
        send_random_bytes(2);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic apply_settings(input logic [7:0] addr, input logic [7:0] fc,
                                  input logic [15:0] watch, input logic [15:0] limit,
                                  input logic junk_write);
        write_reg(CFG_SLAVE_ADDRESS, {rand_byte(), addr});
        write_reg(CFG_FUNCTION_CODE, {rand_byte(), fc});
        write_reg(CFG_WATCHED_REGISTER, watch);
        write_reg(CFG_JUMP_LIMIT, limit);
        if (junk_write) begin
            write_reg(CFG_IDX_UNUSED, 16'($urandom_range(0, 65535)));
        end
        cfg_ch.valid <= 1'b0;
        cur_addr  = addr;
        cur_fc    = fc;
        cur_watch = watch;
        cur_limit = limit;
        settings_count++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase();
        int start;
        int r;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                if ($urandom_range(0, 9) < 7) begin
                    send_request(cur_watch);
                end else begin
                    send_request(16'($urandom_range(0, 65535)));
                end
                send_response(next_count(), 8);
            end else if (r < 65) begin
                send_request(cur_watch);
                send_response(next_count(), $urandom_range(0, 7));
            end else if (r < 73) begin
                send_byte(cur_addr);
                send_byte(cur_fc);
                send_random_bytes($urandom_range(17, 24));
            end else if (r < 80) begin
                send_byte(cur_addr);
                send_byte(cur_fc);
                send_byte(cur_addr);
                send_byte(cur_fc);
                send_random_bytes($urandom_range(2, 6));
            end else if (r < 90) begin
                send_random_bytes($urandom_range(1, 6));
            end else begin
                send_byte(cur_addr);
                send_byte(rand_byte());
            end
        end
        byte_ch.valid <= 1'b0;
    endtask

    initial begin
        int free_run;
        int stall;
        result_ch.ready <= 1'b0;
        free_run = 0;
        stall    = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
                if (free_run > 0) begin
                    free_run--;
                end else if ($urandom_range(0, 99) < 3) begin
                    free_run = $urandom_range(100, 300);
                end else if ($urandom_range(0, 99) < 20) begin
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 3);
                end
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (byte_ch.valid && byte_ch.ready) ||
                (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
            if (idle >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.rx_byte <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        cur_addr        = RST_SLAVE_ADDRESS;
        cur_fc          = RST_FUNCTION_CODE;
        cur_watch       = RST_WATCHED_REGISTER;
        cur_limit       = RST_JUMP_LIMIT;
        meter           = 64'd5000;
        no_gap          = 1'b0;
        bytes_sent      = 0;
        settings_count  = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 21; i++) begin
            send_byte(directed_bytes[i]);
        end
        byte_ch.valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                case (p)
                    1: apply_settings(8'h00, 8'hFF, 16'h0000, 16'h0000, 1'b0);
                    2: apply_settings(8'hFF, 8'h00, 16'hFFFF, 16'hFFFF, 1'b0);
                    3: apply_settings(rand_byte(), rand_byte(),
                                      16'($urandom_range(0, 65535)), 16'd1, 1'b1);
                    default: apply_settings(rand_byte(), rand_byte(),
                                            16'($urandom_range(0, 65535)),
                                            ($urandom_range(0, 4) == 0) ?
                                                16'($urandom_range(0, 65535)) :
                                                16'($urandom_range(0, 500)),
                                            1'b0);
                endcase
                meter = 64'($urandom_range(0, 20000));
            end
            no_gap = ($urandom_range(0, 3) == 0);
            run_phase();
        end

        do @(posedge i_clk); while (outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes under %0d register settings; %0d readings compared, %0d held back.",
                 bytes_sent, settings_count, checked, held_seen);
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d readings still expected", mismatches, outstanding);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/mbsn_pkg.sv
design/mbsn_if.sv
design/mbsn_cfg_regs.sv
design/mbsn_frame.sv
design/mbsn_hold.sv
design/modbus_register_read_sniffer.sv
design/mbsn_checker.sv
tb/sv/modbus_register_read_sniffer_checker.sv
tb/sv/modbus_register_read_sniffer_tb.sv
